// ===== src/lgsf_pkg.sv =====
package lgsf_pkg;

    localparam int IDX_W     = 10;
    localparam int COLOR_W   = 32;
    localparam int COORD_W   = 14;
    localparam int LEN_W     = 7;
    localparam int POS_W     = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic [MODE_W-1:0] SPREAD_PAD     = 2'd0;
    localparam logic [MODE_W-1:0] SPREAD_REPEAT  = 2'd1;
    localparam logic [MODE_W-1:0] SPREAD_REFLECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_POS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_MODE = 2'd3;

    // one queued request: a table write or a span fetch
    typedef struct packed {
        logic               act;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LEN_W-1:0]   len;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [POS_W-1:0]  x_step;
        logic [POS_W-1:0]  y_step;
        logic [POS_W-1:0]  base;
        logic [MODE_W-1:0] mode;
    } cfg_t;

endpackage

// ===== src/lgsf_ram.sv =====
module lgsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lgsf_queue.sv =====
module lgsf_queue
    import lgsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  req_t    push_data,
    input  logic    pop,
    output req_t    head,
    output q_stat_t q_stat
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    req_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== src/lgsf_front.sv =====
module lgsf_front
    import lgsf_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int MAX_SPAN   = 64
) (
    input  logic               in_valid,
    input  logic               action,
    input  logic [IDX_W-1:0]   table_index,
    input  logic [COLOR_W-1:0] table_color,
    input  logic [COORD_W-1:0] span_x,
    input  logic [COORD_W-1:0] span_y,
    input  logic [LEN_W-1:0]   span_length,
    input  q_stat_t            q_stat,
    output logic               in_stall,
    output logic               q_push,
    output req_t               q_entry
);

    logic keep;
    logic [LEN_W-1:0] len_clamp;

    // writes past the table and empty spans leave no trace
    always_comb
    begin
        if (action == ACT_WRITE)
        begin
            keep = (32'(table_index) < 32'(TABLE_SIZE));
        end
        else
        begin
            keep = (span_length != '0);
        end
        len_clamp = (span_length > LEN_W'(MAX_SPAN)) ? LEN_W'(MAX_SPAN) : span_length;
    end

    assign in_stall      = q_stat.full;
    assign q_push        = in_valid && !q_stat.full && keep;
    assign q_entry.act   = action;
    assign q_entry.index = table_index;
    assign q_entry.color = table_color;
    assign q_entry.x     = span_x;
    assign q_entry.y     = span_y;
    assign q_entry.len   = len_clamp;

endmodule

// ===== src/lgsf_back.sv =====
module lgsf_back
    import lgsf_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int MAX_SPAN   = 64,
    parameter int FRAC_BITS  = 8,
    localparam int AW = $clog2(TABLE_SIZE)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  req_t               head,
    input  q_stat_t            q_stat,
    output logic               q_pop,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [COLOR_W-1:0] ram_wdata,
    output logic               ram_re,
    output logic [AW-1:0]      ram_raddr,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               last_pixel
);

    localparam int CW  = $clog2(MAX_SPAN + 1);
    localparam int PRW = COORD_W + 1 + POS_W;
    localparam int SW  = PRW + 2;
    localparam int IW  = POS_W + 1 - FRAC_BITS;
    localparam int UW  = IW + 1;
    localparam int LW  = $clog2(2 * TABLE_SIZE);
    localparam int RW  = UW + 3;
    localparam int PW  = UW + RW;
    localparam int SH  = UW + LW;
    localparam int HALF_Q = 1 << (FRAC_BITS - 1);

    localparam longint N1      = TABLE_SIZE;
    localparam longint N2      = 2 * TABLE_SIZE;
    localparam longint HALF_IX = longint'(1) << (IW - 1);
    // offsets that lift any index to a non-negative multiple-preserving value
    localparam longint OFF_N1   = ((HALF_IX + N1 - 1) / N1) * N1;
    localparam longint OFF_N2   = ((HALF_IX + N2 - 1) / N2) * N2;
    localparam longint RECIP_N1 = ((longint'(1) << SH) + N1 - 1) / N1;
    localparam longint RECIP_N2 = ((longint'(1) << SH) + N2 - 1) / N2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic [POS_W-1:0] r;
        if (v[SW-1:POS_W-1] == {(SW-POS_W+1){v[SW-1]}})
        begin
            r = v[POS_W-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic signed [POS_W-1:0] x_step_s, y_step_s, base_s;
    logic is_rep, is_refl;

    logic [1:0]              state_reg, state_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic signed [PRW-1:0]   px_reg, px_next;
    logic signed [PRW-1:0]   py_reg, py_next;
    logic                    issue;
    logic                    advance;
    logic                    pipe_empty;
    logic signed [SW-1:0]    start_sum;

    logic signed [POS_W:0]   rnd_sum;
    logic signed [IW-1:0]    idx;
    logic [AW-1:0]           pad_idx;
    logic [UW-1:0]           off_sel;
    logic [RW-1:0]           recip_sel;
    logic [LW:0]             l_sel;
    logic [UW-1:0]           u_next;
    logic [PW-1:0]           prod;
    logic [UW-1:0]           ql;
    logic [LW-1:0]           fold;

    logic          s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic [UW-1:0] s1_u_reg, s2_u_reg;
    logic [UW-1:0] s2_q_reg;
    logic [LW-1:0] s3_m_reg;
    logic [AW-1:0] s1_pad_reg, s2_pad_reg, s3_pad_reg;
    logic          s1_last_reg, s2_last_reg, s3_last_reg, out_last_reg;

    assign x_step_s = cfg.x_step;
    assign y_step_s = cfg.y_step;
    assign base_s   = cfg.base;
    assign is_rep   = (cfg.mode == SPREAD_REPEAT);
    assign is_refl  = (cfg.mode == SPREAD_REFLECT);

    assign advance    = !out_v_reg || !out_stall;
    assign pipe_empty = !s1_v_reg && !s2_v_reg && !s3_v_reg;
    assign start_sum  = SW'(base_s) + SW'(px_reg) + SW'(py_reg);

    // sequencer: table writes wait for in-flight reads to drain
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    if (head.act == ACT_FETCH)
                    begin
                        q_pop      = 1'b1;
                        px_next    = PRW'($signed({1'b0, head.x})) * PRW'(x_step_s);
                        py_next    = PRW'($signed({1'b0, head.y})) * PRW'(y_step_s);
                        rem_next   = CW'(head.len);
                        state_next = ST_SUM;
                    end
                    else if (pipe_empty)
                    begin
                        q_pop  = 1'b1;
                        ram_we = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                pos_next   = sat_pos(start_sum);
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    issue    = 1'b1;
                    pos_next = sat_pos(SW'(pos_reg) + SW'(x_step_s));
                    rem_next = CW'(rem_reg - 1'b1);
                    if (rem_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
    end

    assign ram_waddr = AW'(head.index);
    assign ram_wdata = head.color;

    // moduli track spread mode; user keeps it static per span, unenforced
    always_comb
    begin
        if (is_refl)
        begin
            off_sel   = UW'(OFF_N2);
            recip_sel = RW'(RECIP_N2);
            l_sel     = (LW+1)'(N2);
        end
        else
        begin
            off_sel   = UW'(OFF_N1);
            recip_sel = RW'(RECIP_N1);
            l_sel     = (LW+1)'(N1);
        end
    end

    // stage 1: round to index, clamp for pad, bias for modulo
    always_comb
    begin
        rnd_sum = (POS_W+1)'(pos_reg) + (POS_W+1)'(HALF_Q);
        idx     = IW'(rnd_sum >>> FRAC_BITS);
        if (idx[IW-1])
        begin
            pad_idx = '0;
        end
        else if (idx >= IW'(TABLE_SIZE))
        begin
            pad_idx = AW'(TABLE_SIZE - 1);
        end
        else
        begin
            pad_idx = AW'(idx);
        end
        u_next = UW'(idx) + off_sel;
    end

    // stage 2: quotient by reciprocal, stage 3: remainder
    assign prod = PW'(s1_u_reg) * PW'(recip_sel);
    assign ql   = UW'(s2_q_reg * UW'(l_sel));

    // stage 4: mirror for reflect and pick the table address
    always_comb
    begin
        fold = LW'(N2 - 1) - s3_m_reg;
        if (is_refl)
        begin
            ram_raddr = (s3_m_reg >= LW'(N1)) ? AW'(fold) : AW'(s3_m_reg);
        end
        else if (is_rep)
        begin
            ram_raddr = AW'(s3_m_reg);
        end
        else
        begin
            ram_raddr = s3_pad_reg;
        end
    end

    assign ram_re = advance && s3_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            out_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_u_reg     <= u_next;
            s1_pad_reg   <= pad_idx;
            s1_last_reg  <= (rem_reg == CW'(1));
            s2_u_reg     <= s1_u_reg;
            s2_q_reg     <= UW'(prod >> SH);
            s2_pad_reg   <= s1_pad_reg;
            s2_last_reg  <= s1_last_reg;
            s3_m_reg     <= LW'(s2_u_reg - ql);
            s3_pad_reg   <= s2_pad_reg;
            s3_last_reg  <= s2_last_reg;
            out_last_reg <= s3_last_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign last_pixel = out_last_reg;

endmodule

// ===== src/linear_gradient_span_fetch.sv =====
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  action, table_index, table_color,
//                                          span_x, span_y, span_length
// out      source     out_valid / out_stall pixel_color, last_pixel
// cfg      sink       cfg_write            cfg_index, cfg_data
//
// the sequencer pops the request and forms the x and y products, then forms the saturated
// start sum, then issues one pixel per cycle while the output is not stalled
// after its issue a pixel passes three index stages and the table read
// a table write waits until the index pipeline is empty of reads
// reset clears control state only; the colour table is not cleared
// an output stall freezes the whole index pipeline; the request queue keeps taking requests
module linear_gradient_span_fetch
    import lgsf_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int MAX_SPAN   = 64,
    parameter int FRAC_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [IDX_W-1:0]     table_index,
    input  logic [COLOR_W-1:0]   table_color,
    input  logic [COORD_W-1:0]   span_x,
    input  logic [COORD_W-1:0]   span_y,
    input  logic [LEN_W-1:0]     span_length,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COLOR_W-1:0]   pixel_color,
    output logic                 last_pixel
);

    localparam int AW = $clog2(TABLE_SIZE);

    logic [POS_W-1:0]  x_step_reg, y_step_reg, base_reg;
    logic [MODE_W-1:0] mode_reg;
    cfg_t              cfg;

    logic    q_push, q_pop;
    req_t    q_entry, q_head;
    q_stat_t q_stat;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [COLOR_W-1:0] ram_wdata, ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg <= '0;
            y_step_reg <= '0;
            base_reg   <= '0;
            mode_reg   <= SPREAD_PAD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_X_STEP:      x_step_reg <= cfg_data;
                CFG_Y_STEP:      y_step_reg <= cfg_data;
                CFG_BASE_POS:    base_reg   <= cfg_data;
                CFG_SPREAD_MODE: mode_reg   <= cfg_data[MODE_W-1:0];
                default:         mode_reg   <= mode_reg;
            endcase
        end
    end

    assign cfg.x_step = x_step_reg;
    assign cfg.y_step = y_step_reg;
    assign cfg.base   = base_reg;
    assign cfg.mode   = mode_reg;

    lgsf_front #(
        .TABLE_SIZE(TABLE_SIZE),
        .MAX_SPAN  (MAX_SPAN)
    ) u_front (
        .in_valid   (in_valid),
        .action     (action),
        .table_index(table_index),
        .table_color(table_color),
        .span_x     (span_x),
        .span_y     (span_y),
        .span_length(span_length),
        .q_stat     (q_stat),
        .in_stall   (in_stall),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    lgsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_entry),
        .pop      (q_pop),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    lgsf_back #(
        .TABLE_SIZE(TABLE_SIZE),
        .MAX_SPAN  (MAX_SPAN),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .last_pixel(last_pixel)
    );

    lgsf_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(TABLE_SIZE)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign pixel_color = ram_rdata;

    // a table write must never land while a pixel read is in flight
    a_write_read_apart: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("table write collides with pixel read");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("request queue popped while empty");

    a_raddr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (32'(ram_raddr) < 32'(TABLE_SIZE)))
        else $error("spread index outside the table");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(q_push))
        else $error("request queue filled without a push");

endmodule
